>>> hw/rtl/eadwf_pkg.sv
// types, constants and state encoding for the edge-aware dilated window filter
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package eadwf_pkg;

	localparam int PIX_W = 16;
	localparam int COL_W = 13;
	localparam int ROW_W = 14;
	localparam int HGT_W = 15;
	localparam int SPC_W = 4;
	localparam int LIN_W = 27;
	localparam int TAP_W = 3;
	localparam int WT_W  = 22;
	localparam int VAL_W = 48;
	localparam int NRM_W = 28;
	localparam int CNT_W = 6;

	localparam logic [NRM_W-1:0] RANGE_OFFSET = NRM_W'(1000);
	localparam logic [VAL_W-1:0] RECIP_NUM    = VAL_W'(1000) << 20;
	localparam logic [PIX_W-1:0] PIX_MAX      = 16'hFFFF;
	localparam logic [HGT_W-1:0] HGT_CAP      = HGT_W'(16384);

	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_TAP_SPACING  = 2'd2;
	localparam logic [1:0] REG_WIDE_KERNEL  = 2'd3;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STEP,
		ST_DECIDE,
		ST_CTR_RD,
		ST_CTR_LD,
		ST_TAP_CHK,
		ST_TAP_RD,
		ST_TAP_LD,
		ST_TAP_DIV,
		ST_TAP_WAIT,
		ST_TAP_MUL,
		ST_TAP_ACC,
		ST_FIN_DIV,
		ST_FIN_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [COL_W-1:0] image_width;
		logic [HGT_W-1:0] image_height;
		logic [SPC_W-1:0] tap_spacing;
		logic             wide_kernel;
	} cfg_t;

	typedef struct packed {
		logic take;
		logic step;
		logic tap_init;
		logic ctr_rd;
		logic ctr_ld;
		logic tap_chk;
		logic tap_rd;
		logic tap_ld;
		logic div_wt;
		logic wt_ld;
		logic mul;
		logic acc;
		logic tap_adv;
		logic fin_div;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic elig;
		logic tap_ok;
		logic tap_last;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

>>> hw/rtl/eadwf_div.sv
// restoring divider, one quotient bit per cycle
// depends on eadwf_pkg
`timescale 1ns / 1ps

module eadwf_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [eadwf_pkg::VAL_W-1:0] dvd,
	input  logic [eadwf_pkg::NRM_W-1:0] dsr,
	output logic                        done,
	output logic [eadwf_pkg::VAL_W-1:0] quot
);

	localparam logic [eadwf_pkg::CNT_W-1:0] LAST_STEP = eadwf_pkg::CNT_W'(eadwf_pkg::VAL_W - 1);

	logic                        busy_q;
	logic                        done_q;
	logic [eadwf_pkg::CNT_W-1:0] cnt_q;
	logic [eadwf_pkg::NRM_W-1:0] rem_q;
	logic [eadwf_pkg::NRM_W-1:0] dsr_q;
	logic [eadwf_pkg::VAL_W-1:0] q_q;
	logic [eadwf_pkg::NRM_W:0]   rem_sh;
	logic [eadwf_pkg::NRM_W:0]   rem_sub;
	logic                        ge;

	assign rem_sh  = {rem_q, q_q[eadwf_pkg::VAL_W-1]};
	assign ge      = rem_sh >= {1'b0, dsr_q};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= dsr;
			q_q   <= dvd;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[eadwf_pkg::NRM_W-1:0] : rem_sh[eadwf_pkg::NRM_W-1:0];
			q_q   <= {q_q[eadwf_pkg::VAL_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

>>> hw/rtl/eadwf_dp.sv
// datapath: row store, frame counters, tap walk, weight and sum accumulation, result register
// depends on eadwf_pkg and eadwf_div
`timescale 1ns / 1ps

module eadwf_dp #(
	parameter int MAX_WIDTH   = 4096,
	parameter int MAX_SPACING = 8,
	parameter int HALF_WINDOW = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  eadwf_pkg::cfg_t              cfg,
	input  logic                         cfg_wr,
	input  eadwf_pkg::cmd_t              cmd,
	output eadwf_pkg::sts_t              sts,
	input  logic                         in_cmd,
	input  logic [eadwf_pkg::PIX_W-1:0]  in_pix,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [eadwf_pkg::PIX_W-1:0]  out_value,
	output logic [eadwf_pkg::ROW_W-1:0]  out_row,
	output logic [11:0]                  out_col,
	output logic                         out_last
);

	localparam int STORE_ROWS = 2 * HALF_WINDOW * MAX_SPACING + 1;
	localparam int DEPTH      = STORE_ROWS * MAX_WIDTH;
	localparam int AW         = $clog2(DEPTH);
	localparam int SL_W       = $clog2(STORE_ROWS);
	localparam logic [AW-1:0] MW = AW'(MAX_WIDTH);
	localparam logic [SL_W-1:0] SLOT_LAST = SL_W'(STORE_ROWS - 1);
	localparam logic signed [9:0] ROWS_S = 10'(STORE_ROWS);
	localparam logic [eadwf_pkg::COL_W-1:0] WID_CAP =
		(MAX_WIDTH > 8191) ? 13'd8191 : eadwf_pkg::COL_W'(MAX_WIDTH);
	localparam logic [eadwf_pkg::SPC_W-1:0] SPC_CAP =
		(MAX_SPACING > 15) ? 4'd15 : eadwf_pkg::SPC_W'(MAX_SPACING);
	localparam logic [eadwf_pkg::TAP_W-1:0] HW = eadwf_pkg::TAP_W'(HALF_WINDOW);

	logic [eadwf_pkg::PIX_W-1:0] mem [DEPTH];

	logic [eadwf_pkg::COL_W-1:0] eff_w;
	logic [eadwf_pkg::HGT_W-1:0] eff_h;
	logic [eadwf_pkg::SPC_W-1:0] eff_s;
	logic [eadwf_pkg::TAP_W-1:0] rad;
	logic [4:0]                  dil;
	logic [eadwf_pkg::LIN_W-1:0] n_q;
	logic [eadwf_pkg::LIN_W-1:0] lag_q;

	logic                        cmd_q;
	logic [eadwf_pkg::PIX_W-1:0] pix_q;

	logic [eadwf_pkg::COL_W-1:0] in_col_q;
	logic [eadwf_pkg::ROW_W-1:0] in_row_q;
	logic [SL_W-1:0]             in_slot_q;
	logic [eadwf_pkg::LIN_W-1:0] in_lin_q;
	logic                        in_done_q;
	logic [eadwf_pkg::COL_W-1:0] emit_col_q;
	logic [eadwf_pkg::ROW_W-1:0] emit_row_q;
	logic [SL_W-1:0]             emit_slot_q;
	logic [eadwf_pkg::LIN_W-1:0] emit_lin_q;
	logic                        elig_q;

	logic signed [eadwf_pkg::TAP_W-1:0] ta_q;
	logic signed [eadwf_pkg::TAP_W-1:0] tb_q;
	logic [AW-1:0]               tap_addr_q;
	logic [eadwf_pkg::PIX_W-1:0] rdata_q;
	logic [eadwf_pkg::PIX_W-1:0] ctr_q;
	logic [eadwf_pkg::PIX_W-1:0] t_q;
	logic [eadwf_pkg::WT_W-1:0]  wt_q;
	logic [eadwf_pkg::VAL_W-1:0] prod_q;
	logic [eadwf_pkg::VAL_W-1:0] val_q;
	logic [eadwf_pkg::NRM_W-1:0] norm_q;

	logic                        ov_q;
	logic [eadwf_pkg::PIX_W-1:0] ovalue_q;
	logic [eadwf_pkg::ROW_W-1:0] orow_q;
	logic [11:0]                 ocol_q;
	logic                        olast_q;

	logic [eadwf_pkg::LIN_W:0]   e_plus;
	logic [eadwf_pkg::LIN_W:0]   nm1;
	logic [eadwf_pkg::LIN_W:0]   need;
	logic                        pix_take;
	logic                        in_col_end;
	logic                        in_row_end;
	logic                        last_pos;

	logic signed [8:0]  roff;
	logic signed [8:0]  coff;
	logic signed [15:0] rr;
	logic signed [15:0] cc;
	logic signed [9:0]  ssum;
	logic signed [9:0]  swrap;
	logic               tap_ok;
	logic               tap_last;
	logic [AW-1:0]      tap_addr;
	logic [AW-1:0]      ctr_addr;
	logic [AW-1:0]      in_addr;
	logic [AW-1:0]      rd_addr;
	logic [eadwf_pkg::TAP_W-1:0] aa;
	logic [eadwf_pkg::TAP_W-1:0] ab;
	logic               inner;
	logic [eadwf_pkg::PIX_W-1:0] dabs;

	logic                        div_start;
	logic [eadwf_pkg::VAL_W-1:0] div_dvd;
	logic [eadwf_pkg::NRM_W-1:0] div_dsr;
	logic                        div_done;
	logic [eadwf_pkg::VAL_W-1:0] div_quot;

	// clamped configuration
	always_comb begin
		eff_w = (cfg.image_width == '0) ? eadwf_pkg::COL_W'(1) :
			((cfg.image_width > WID_CAP) ? WID_CAP : cfg.image_width);
		eff_h = (cfg.image_height == '0) ? eadwf_pkg::HGT_W'(1) :
			((cfg.image_height > eadwf_pkg::HGT_CAP) ? eadwf_pkg::HGT_CAP : cfg.image_height);
		eff_s = (cfg.tap_spacing == '0) ? eadwf_pkg::SPC_W'(1) :
			((cfg.tap_spacing > SPC_CAP) ? SPC_CAP : cfg.tap_spacing);
		rad   = cfg.wide_kernel ? HW : eadwf_pkg::TAP_W'(1);
		dil   = 5'(rad * eff_s);
	end

	always_ff @(posedge clk) begin
		n_q   <= eadwf_pkg::LIN_W'(eff_w * eff_h);
		lag_q <= eadwf_pkg::LIN_W'(dil * eff_w) + eadwf_pkg::LIN_W'(dil);
	end

	// emission rule
	always_comb begin
		e_plus     = {1'b0, emit_lin_q} + {1'b0, lag_q};
		nm1        = {1'b0, n_q} - 1'b1;
		need       = (e_plus < nm1) ? e_plus : nm1;
		pix_take   = (cmd_q == eadwf_pkg::CMD_PIXEL) && !in_done_q;
		in_col_end = (in_col_q + 1'b1) >= eff_w;
		in_row_end = ({1'b0, in_row_q} + 1'b1) >= eff_h;
		last_pos   = ({1'b0, emit_lin_q} == nm1);
	end

	// tap geometry
	always_comb begin
		roff  = $signed({{6{ta_q[eadwf_pkg::TAP_W-1]}}, ta_q}) * $signed({5'b0, eff_s});
		coff  = $signed({{6{tb_q[eadwf_pkg::TAP_W-1]}}, tb_q}) * $signed({5'b0, eff_s});
		rr    = $signed({2'b00, emit_row_q}) + $signed({{7{roff[8]}}, roff});
		cc    = $signed({3'b000, emit_col_q}) + $signed({{7{coff[8]}}, coff});
		ssum  = $signed({{(10-SL_W){1'b0}}, emit_slot_q}) + $signed({roff[8], roff});
		if (ssum < 0) begin
			swrap = ssum + ROWS_S;
		end else if (ssum >= ROWS_S) begin
			swrap = ssum - ROWS_S;
		end else begin
			swrap = ssum;
		end
		tap_ok   = !rr[15] && (rr[14:0] < eff_h) && !cc[15] && (cc[13:0] < {1'b0, eff_w});
		tap_last = (ta_q == $signed(rad)) && (tb_q == $signed(rad));
		tap_addr = AW'(swrap[SL_W-1:0]) * MW + AW'(cc[eadwf_pkg::COL_W-1:0]);
		ctr_addr = AW'(emit_slot_q) * MW + AW'(emit_col_q);
		in_addr  = AW'(in_slot_q) * MW + AW'(in_col_q);
		rd_addr  = cmd.ctr_rd ? ctr_addr : tap_addr_q;
		aa       = ta_q[eadwf_pkg::TAP_W-1] ? eadwf_pkg::TAP_W'(-ta_q) : ta_q;
		ab       = tb_q[eadwf_pkg::TAP_W-1] ? eadwf_pkg::TAP_W'(-tb_q) : tb_q;
		inner    = cfg.wide_kernel && (aa < HW) && (ab < HW);
		dabs     = (t_q > ctr_q) ? (t_q - ctr_q) : (ctr_q - t_q);
	end

	// row store
	always_ff @(posedge clk) begin
		if (cmd.step && pix_take) begin
			mem[in_addr] <= pix_q;
		end
		if (cmd.ctr_rd || cmd.tap_rd) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_slot_q   <= '0;
			in_lin_q    <= '0;
			in_done_q   <= 1'b0;
			emit_col_q  <= '0;
			emit_row_q  <= '0;
			emit_slot_q <= '0;
			emit_lin_q  <= '0;
			elig_q      <= 1'b0;
		end else if (cfg_wr || (cmd.emit && last_pos)) begin
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_slot_q   <= '0;
			in_lin_q    <= '0;
			in_done_q   <= 1'b0;
			emit_col_q  <= '0;
			emit_row_q  <= '0;
			emit_slot_q <= '0;
			emit_lin_q  <= '0;
		end else if (cmd.step) begin
			if (pix_take) begin
				elig_q <= {1'b0, in_lin_q} >= need;
				if (in_col_end) begin
					in_col_q <= '0;
					if (in_row_end) begin
						in_row_q  <= '0;
						in_slot_q <= '0;
						in_lin_q  <= '0;
						in_done_q <= 1'b1;
					end else begin
						in_row_q  <= in_row_q + 1'b1;
						in_slot_q <= (in_slot_q == SLOT_LAST) ? '0 : in_slot_q + 1'b1;
						in_lin_q  <= in_lin_q + 1'b1;
					end
				end else begin
					in_col_q <= in_col_q + 1'b1;
					in_lin_q <= in_lin_q + 1'b1;
				end
			end else begin
				elig_q <= in_done_q;
			end
		end else if (cmd.emit) begin
			emit_lin_q <= emit_lin_q + 1'b1;
			if ((emit_col_q + 1'b1) >= eff_w) begin
				emit_col_q  <= '0;
				emit_row_q  <= emit_row_q + 1'b1;
				emit_slot_q <= (emit_slot_q == SLOT_LAST) ? '0 : emit_slot_q + 1'b1;
			end else begin
				emit_col_q <= emit_col_q + 1'b1;
			end
		end
	end

	// item latch, tap walk and accumulation
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cmd_q <= in_cmd;
			pix_q <= in_pix;
		end
		if (cmd.tap_init) begin
			ta_q   <= -$signed(rad);
			tb_q   <= -$signed(rad);
			val_q  <= '0;
			norm_q <= '0;
		end
		if (cmd.tap_adv) begin
			if (tb_q == $signed(rad)) begin
				tb_q <= -$signed(rad);
				ta_q <= ta_q + 1'b1;
			end else begin
				tb_q <= tb_q + 1'b1;
			end
		end
		if (cmd.tap_chk) begin
			tap_addr_q <= tap_addr;
		end
		if (cmd.ctr_ld) begin
			ctr_q <= rdata_q;
		end
		if (cmd.tap_ld) begin
			t_q <= rdata_q;
		end
		if (cmd.wt_ld) begin
			wt_q <= inner ? {div_quot[eadwf_pkg::WT_W-2:0], 1'b0} : div_quot[eadwf_pkg::WT_W-1:0];
		end
		if (cmd.mul) begin
			prod_q <= eadwf_pkg::VAL_W'(wt_q * t_q);
			norm_q <= norm_q + eadwf_pkg::NRM_W'(wt_q);
		end
		if (cmd.acc) begin
			val_q <= val_q + prod_q;
		end
	end

	// shared divider for tap weights and the final quotient
	assign div_start = cmd.div_wt || cmd.fin_div;
	assign div_dvd   = cmd.fin_div ? (val_q + eadwf_pkg::VAL_W'(norm_q >> 1)) : eadwf_pkg::RECIP_NUM;
	assign div_dsr   = cmd.fin_div ? norm_q :
		(eadwf_pkg::NRM_W'(dabs) + eadwf_pkg::RANGE_OFFSET);

	eadwf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (div_dvd),
		.dsr    (div_dsr),
		.done   (div_done),
		.quot   (div_quot)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			ovalue_q <= (div_quot > eadwf_pkg::VAL_W'(eadwf_pkg::PIX_MAX)) ?
				eadwf_pkg::PIX_MAX : div_quot[eadwf_pkg::PIX_W-1:0];
			orow_q   <= emit_row_q;
			ocol_q   <= emit_col_q[11:0];
			olast_q  <= last_pos;
		end
	end

	assign out_valid = ov_q;
	assign out_value = ovalue_q;
	assign out_row   = orow_q;
	assign out_col   = ocol_q;
	assign out_last  = olast_q;

	assign sts.elig     = elig_q;
	assign sts.tap_ok   = tap_ok;
	assign sts.tap_last = tap_last;
	assign sts.div_done = div_done;
	assign sts.out_free = !ov_q || out_ready;

endmodule

>>> hw/rtl/eadwf_ctrl.sv
// controller state machine sequencing one item through the datapath
// depends on eadwf_pkg
`timescale 1ns / 1ps

module eadwf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  eadwf_pkg::sts_t sts,
	output eadwf_pkg::cmd_t cmd
);

	eadwf_pkg::state_t state_q;
	eadwf_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eadwf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			eadwf_pkg::ST_IDLE:     if (in_valid) state_d = eadwf_pkg::ST_STEP;
			eadwf_pkg::ST_STEP:     state_d = eadwf_pkg::ST_DECIDE;
			eadwf_pkg::ST_DECIDE:   state_d = sts.elig ? eadwf_pkg::ST_CTR_RD : eadwf_pkg::ST_IDLE;
			eadwf_pkg::ST_CTR_RD:   state_d = eadwf_pkg::ST_CTR_LD;
			eadwf_pkg::ST_CTR_LD:   state_d = eadwf_pkg::ST_TAP_CHK;
			eadwf_pkg::ST_TAP_CHK: begin
				if (sts.tap_ok) begin
					state_d = eadwf_pkg::ST_TAP_RD;
				end else if (sts.tap_last) begin
					state_d = eadwf_pkg::ST_FIN_DIV;
				end
			end
			eadwf_pkg::ST_TAP_RD:   state_d = eadwf_pkg::ST_TAP_LD;
			eadwf_pkg::ST_TAP_LD:   state_d = eadwf_pkg::ST_TAP_DIV;
			eadwf_pkg::ST_TAP_DIV:  state_d = eadwf_pkg::ST_TAP_WAIT;
			eadwf_pkg::ST_TAP_WAIT: if (sts.div_done) state_d = eadwf_pkg::ST_TAP_MUL;
			eadwf_pkg::ST_TAP_MUL:  state_d = eadwf_pkg::ST_TAP_ACC;
			eadwf_pkg::ST_TAP_ACC: begin
				state_d = sts.tap_last ? eadwf_pkg::ST_FIN_DIV : eadwf_pkg::ST_TAP_CHK;
			end
			eadwf_pkg::ST_FIN_DIV:  state_d = eadwf_pkg::ST_FIN_WAIT;
			eadwf_pkg::ST_FIN_WAIT: if (sts.div_done) state_d = eadwf_pkg::ST_EMIT;
			eadwf_pkg::ST_EMIT:     if (sts.out_free) state_d = eadwf_pkg::ST_IDLE;
			default:                state_d = eadwf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			eadwf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			eadwf_pkg::ST_STEP:     cmd.step = 1'b1;
			eadwf_pkg::ST_DECIDE:   cmd.tap_init = sts.elig;
			eadwf_pkg::ST_CTR_RD:   cmd.ctr_rd = 1'b1;
			eadwf_pkg::ST_CTR_LD:   cmd.ctr_ld = 1'b1;
			eadwf_pkg::ST_TAP_CHK: begin
				cmd.tap_chk = 1'b1;
				cmd.tap_adv = !sts.tap_ok;
			end
			eadwf_pkg::ST_TAP_RD:   cmd.tap_rd = 1'b1;
			eadwf_pkg::ST_TAP_LD:   cmd.tap_ld = 1'b1;
			eadwf_pkg::ST_TAP_DIV:  cmd.div_wt = 1'b1;
			eadwf_pkg::ST_TAP_WAIT: cmd.wt_ld = sts.div_done;
			eadwf_pkg::ST_TAP_MUL:  cmd.mul = 1'b1;
			eadwf_pkg::ST_TAP_ACC: begin
				cmd.acc     = 1'b1;
				cmd.tap_adv = 1'b1;
			end
			eadwf_pkg::ST_FIN_DIV:  cmd.fin_div = 1'b1;
			eadwf_pkg::ST_FIN_WAIT: cmd = '0;
			eadwf_pkg::ST_EMIT:     cmd.emit = sts.out_free;
			default:                cmd = '0;
		endcase
	end

endmodule

>>> hw/rtl/edge_aware_dilated_window_filter.sv
// top level: configuration registers, controller and datapath of the window filter
// depends on eadwf_pkg, eadwf_ctrl, eadwf_dp
`timescale 1ns / 1ps

// Raster pixels enter on the s_ channel: s_tuser is 0 for a pixel, 1 for a flush
// tick. Each accepted transaction yields at most one smoothed pixel on the m_
// channel with its row, column and an end-of-frame mark on m_tlast. A position is
// emitted once its whole window has arrived; after the last pixel of a frame each
// flush tick drains one pending position. One item is worked at a time.
// Taps outside the image are skipped. The window is 3x3, or 5x5 with the wide
// kernel at the default HALF_WINDOW. The shared 48-step divider computes each tap
// weight and the final quotient. The result waits in an output register: while
// m_tready is low the next transaction is still taken and processed, and the
// block holds only when a second result is ready to be written. Reset clears the
// frame counters and loads the default registers; the row store is not cleared.
// An APB write restarts the frame.

module edge_aware_dilated_window_filter #(
	parameter int MAX_WIDTH   = 4096,
	parameter int MAX_SPACING = 8,
	parameter int HALF_WINDOW = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // pixel_value
	input  logic [0:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // smoothed_value, out_row, out_col, zero fill
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	eadwf_pkg::cfg_t cfg_q;
	eadwf_pkg::cmd_t cmd;
	eadwf_pkg::sts_t sts;
	logic            cfg_wr;
	logic [15:0]     out_value;
	logic [13:0]     out_row;
	logic [11:0]     out_col;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= 13'd4096;
			cfg_q.image_height <= 15'd1024;
			cfg_q.tap_spacing  <= 4'd1;
			cfg_q.wide_kernel  <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				eadwf_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[12:0];
				eadwf_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[14:0];
				eadwf_pkg::REG_TAP_SPACING:  cfg_q.tap_spacing  <= pwdata[3:0];
				eadwf_pkg::REG_WIDE_KERNEL:  cfg_q.wide_kernel  <= pwdata[0];
				default:                     cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			eadwf_pkg::REG_IMAGE_WIDTH:  prdata = {19'd0, cfg_q.image_width};
			eadwf_pkg::REG_IMAGE_HEIGHT: prdata = {17'd0, cfg_q.image_height};
			eadwf_pkg::REG_TAP_SPACING:  prdata = {28'd0, cfg_q.tap_spacing};
			eadwf_pkg::REG_WIDE_KERNEL:  prdata = {31'd0, cfg_q.wide_kernel};
			default:                     prdata = '0;
		endcase
	end

	eadwf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	eadwf_dp #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_SPACING (MAX_SPACING),
		.HALF_WINDOW (HALF_WINDOW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cfg_wr    (cfg_wr),
		.cmd       (cmd),
		.sts       (sts),
		.in_cmd    (s_tuser[0]),
		.in_pix    (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_value (out_value),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_last  (m_tlast)
	);

	assign m_tdata = {6'd0, out_col, out_row, out_value};

endmodule
